// ===== rtl/core/obb_pkg.sv =====
`default_nettype none
package obb_pkg;

   // number of stored vectors and their slots
   localparam int unsigned NumSlots  = 10;
   localparam int unsigned SlotBits  = 4;
   localparam logic [SlotBits-1:0] SlotCtrA = 4'd0;
   localparam logic [SlotBits-1:0] SlotHalfA = 4'd1;
   localparam logic [SlotBits-1:0] SlotAxA0 = 4'd2;
   localparam logic [SlotBits-1:0] SlotCtrB = 4'd5;
   localparam logic [SlotBits-1:0] SlotHalfB = 4'd6;
   localparam logic [SlotBits-1:0] SlotAxB0 = 4'd7;

   // number of parallel product lanes
   localparam int unsigned NumLanes = 3;

   // number of sequencer steps of one test
   localparam int unsigned NumSteps  = 24;
   localparam int unsigned StepBits  = 5;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;

   // one three-lane job: how to use the sum, sign of lane 1, and the last-step flag
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ROT  = 3'd1,
      OP_OFS  = 3'd2,
      OP_RAD  = 3'd3,
      OP_PROJ = 3'd4,
      OP_RAD2 = 3'd5
   } op_type;

   typedef struct packed {
      op_type   op;
      logic     neg1;
      logic     done;
   } lane_ctrl_type;

   // saturate a wide sum to 32 bits
   function automatic word_type sat32(input logic signed [35:0] v);
      logic signed [35:0] hi;
      logic signed [35:0] lo;
      begin
         hi = 36'sh07FFFFFFF;
         lo = -36'sh080000000;
         if (v > hi) sat32 = 32'sh7FFFFFFF;
         else if (v < lo) sat32 = 32'sh80000000;
         else sat32 = v[31:0];
      end
   endfunction

   // saturate a sum of scaled products to 32 bits
   function automatic word_type sat64(input wide_type v);
      begin
         if (v > 64'sh000000007FFFFFFF) sat64 = 32'sh7FFFFFFF;
         else if (v < -64'sh0000000080000000) sat64 = 32'sh80000000;
         else sat64 = v[31:0];
      end
   endfunction

   // absolute value at 33 bits
   function automatic logic [32:0] abs33(input word_type v);
      logic signed [32:0] e;
      begin
         e = {v[31], v};
         abs33 = (e < 0) ? 33'(-e) : 33'(e);
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/obb_stream_if.sv =====
`default_nettype none
interface obb_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  vector_slot;
   logic signed [31:0] comp_x;
   logic signed [31:0] comp_y;
   logic signed [31:0] comp_z;
   logic        last_vector;
   modport source (output valid, vector_slot, comp_x, comp_y, comp_z, last_vector,
                   input ready);
   modport sink (input valid, vector_slot, comp_x, comp_y, comp_z, last_vector,
                 output ready);
endinterface

interface obb_rsp_if;
   logic valid;
   logic ready;
   logic boxes_overlap;
   modport source (output valid, boxes_overlap, input ready);
   modport sink (input valid, boxes_overlap, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/obb_lane.sv =====
`default_nettype none
// one product lane: registered full product, then shift with floor rounding
module obb_lane #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic signed [63:0] prod
);
   logic signed [63:0] p_ff;
   logic signed [63:0] p_in;

   assign p_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   // arithmetic shift rounds toward minus infinity; kept at full width so
   // a sum of three lanes cannot wrap before it saturates
   assign prod = p_ff >>> FRAC_BITS;
endmodule
`default_nettype wire

// ===== rtl/core/obb_overlap_test_top.sv =====
`default_nettype none
// OBB overlap test (15-axis separating axis test)
// requests on req: vector_slot picks one of ten stored vectors (A center,
// A half sizes, A axes, B center, B half sizes, B axes); comp_x/y/z are Q16.16.
// a request with last_vector set stores its vector, then runs the test and
// sends one rsp with boxes_overlap (1 overlap, 0 separated). other requests
// give no response. slots 10..15 store nothing.
// test: a last request runs 24 sequencer steps feeding three parallel
// multiplier lanes (one 32x32 each, product registered), then the ST_WAIT
// drain, then rsp valid in ST_SEND.
// throughput: one vector per cycle while idle. req ready is low while a test
// runs or its result waits on rsp.
// csr: csr_we writes abs_bias (16 bits, reset 1); the user writes it only while
// the block is idle, the block itself does not enforce this.
// reset (synchronous, active high) clears control state and sets abs_bias to 1;
// vectors must be loaded again before a test. if rsp is stalled the result
// holds in its register and no further request is taken until it is taken.
module obb_overlap_test_top #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   obb_req_if.sink   req,
   obb_rsp_if.source rsp,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] bias_ff;
   obb_pkg::word_type vs_ff [30];
   logic [obb_pkg::StepBits-1:0] step_ff, step_in;
   logic [1:0] drain_ff, drain_in;
   logic sep_ff, sep_in;
   logic res_ff;

   obb_pkg::word_type rm_ff [9];
   obb_pkg::word_type ar_ff [9];
   obb_pkg::word_type t_ff [3];
   obb_pkg::word_type d [3];
   obb_pkg::word_type rad_ff [3];
   logic [4:0] tgt_ff;
   obb_pkg::lane_ctrl_type c1_ff, cur;
   logic [4:0] tgt;
   logic [1:0] ri, rj;
   obb_pkg::word_type la [3];
   obb_pkg::word_type lb [3];
   obb_pkg::wide_type pr [3];
   obb_pkg::wide_type sum;
   obb_pkg::word_type s;
   logic [4:0] vbase;
   logic accept;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_LOAD);
   assign rsp.valid = (state_ff == ST_SEND);
   assign rsp.boxes_overlap = res_ff;
   assign vbase     = 5'(req.vector_slot) * 5'd3;

   // vector store and bias
   always_ff @(posedge clock) begin
      if (accept && req.vector_slot < 4'(obb_pkg::NumSlots)) begin
         vs_ff[vbase]        <= req.comp_x;
         vs_ff[vbase + 5'd1] <= req.comp_y;
         vs_ff[vbase + 5'd2] <= req.comp_z;
      end
      if (reset) bias_ff <= 16'd1;
      else if (csr_we) bias_ff <= csr_wdata;
   end

   function automatic obb_pkg::word_type v(input int sl, input int k);
      v = vs_ff[sl*3+k];
   endfunction

   // center offset, world frame
   always_comb begin
      for (int k = 0; k < 3; k++)
         d[k] = obb_pkg::sat32(36'(v(5, k)) - 36'(v(0, k)));
   end

   // row and column of the rotation entry for the current step
   always_comb begin
      if (step_ff < 5'd3) begin
         ri = 2'd0; rj = 2'(step_ff);
      end else if (step_ff < 5'd6) begin
         ri = 2'd1; rj = 2'(step_ff - 5'd3);
      end else begin
         ri = 2'd2; rj = 2'(step_ff - 5'd6);
      end
   end

   // step table: lane operands for each sequencer step
   always_comb begin
      cur = '{op: obb_pkg::OP_NONE, neg1: 1'b0, done: 1'b0};
      tgt = '0;
      for (int l = 0; l < 3; l++) begin la[l] = '0; lb[l] = '0; end
      if (step_ff < 5'd9) begin
         // rotation entry i,j
         cur.op = obb_pkg::OP_ROT; tgt = step_ff;
         for (int l = 0; l < 3; l++) begin
            la[l] = v(2 + int'(ri), l);
            lb[l] = v(7 + int'(rj), l);
         end
      end else if (step_ff < 5'd12) begin
         cur.op = obb_pkg::OP_OFS; tgt = step_ff - 5'd9;
         for (int l = 0; l < 3; l++) begin
            la[l] = d[l]; lb[l] = v(2 + int'(step_ff) - 9, l);
         end
      end else if (step_ff < 5'd15) begin
         // face axes of A: rb
         cur.op = obb_pkg::OP_RAD; tgt = step_ff - 5'd12;
         for (int l = 0; l < 3; l++) begin
            la[l] = v(6, l); lb[l] = ar_ff[(int'(step_ff) - 12)*3 + l];
         end
      end else if (step_ff < 5'd18) begin
         // face axes of B: ra in lanes, projection uses second job
         cur.op = obb_pkg::OP_RAD; tgt = step_ff - 5'd12;
         for (int l = 0; l < 3; l++) begin
            la[l] = v(1, l); lb[l] = ar_ff[l*3 + int'(step_ff) - 15];
         end
      end else if (step_ff < 5'd21) begin
         cur.op = obb_pkg::OP_PROJ; tgt = step_ff - 5'd15;
         for (int l = 0; l < 3; l++) begin
            la[l] = t_ff[l]; lb[l] = rm_ff[l*3 + int'(step_ff) - 18];
         end
      end else begin
         cur.op = obb_pkg::OP_NONE;
      end
      cur.done = (step_ff == 5'(obb_pkg::NumSteps - 1));
   end

   // three parallel multiplier lanes
   for (genvar g = 0; g < 3; g++) begin : g_lane
      obb_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .a(la[g]), .b(lb[g]), .prod(pr[g]));
   end

   // merge stage: sum lanes, saturate, write results, run compares
   assign sum = pr[0] + pr[1] + pr[2];
   assign s   = obb_pkg::sat64(sum);

   function automatic obb_pkg::wide_type fm(input obb_pkg::word_type a,
                                            input obb_pkg::word_type b);
      begin
         fm = (64'(a) * 64'(b)) >>> FRAC_BITS;
      end
   endfunction

   // edge axes evaluated at the final sequencer steps once matrices are ready
   function automatic logic edge_sep(input int i, input int j);
      int i1, i2, j1, j2;
      obb_pkg::wide_type ra, rb, p;
      obb_pkg::word_type rs;
      begin
         i1 = (i == 2) ? 0 : i + 1; i2 = (i == 0) ? 2 : i - 1;
         j1 = (j == 2) ? 0 : j + 1; j2 = (j == 0) ? 2 : j - 1;
         ra = fm(v(1, i1), ar_ff[i2*3+j]) + fm(v(1, i2), ar_ff[i1*3+j]);
         rb = fm(v(6, j1), ar_ff[i*3+j2]) + fm(v(6, j2), ar_ff[i*3+j1]);
         p  = fm(t_ff[i2], rm_ff[i1*3+j]) - fm(t_ff[i1], rm_ff[i2*3+j]);
         rs = obb_pkg::sat32(36'(obb_pkg::sat64(ra)) + 36'(obb_pkg::sat64(rb)));
         edge_sep = obb_pkg::abs33(obb_pkg::sat64(p)) > {1'b0, rs} &&
                    !rs[31] ? 1'b1 :
                    ($signed({1'b0, obb_pkg::abs33(obb_pkg::sat64(p))}) >
                     $signed({{2{rs[31]}}, rs}));
      end
   endfunction

   logic edge_hit;
   logic [3:0] eidx;
   always_comb begin
      eidx = 4'(int'(step_ff) - 21);
      edge_hit = 1'b0;
      if (step_ff >= 5'd21 && step_ff < 5'd24) begin
         for (int j = 0; j < 3; j++)
            if (edge_sep(int'(eidx), j)) edge_hit = 1'b1;
      end
   end

   logic signed [35:0] lhs, rhs;
   logic face_hit;
   always_comb begin
      face_hit = 1'b0;
      lhs = '0; rhs = '0;
      if (c1_ff.op == obb_pkg::OP_RAD && tgt_ff < 5'd3) begin
         rhs = 36'(obb_pkg::sat32(36'(v(1, int'(tgt_ff[1:0]))) + 36'(s)));
         lhs = 36'(obb_pkg::abs33(t_ff[tgt_ff[1:0]]));
         face_hit = lhs > rhs;
      end else if (c1_ff.op == obb_pkg::OP_PROJ) begin
         rhs = 36'(obb_pkg::sat32(36'(rad_ff[2'(tgt_ff - 5'd3)]) +
               36'(v(6, int'(tgt_ff) - 3))));
         lhs = 36'(obb_pkg::abs33(s));
         face_hit = lhs > rhs;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff; step_in = step_ff; drain_in = drain_ff; sep_in = sep_ff;
      case (state_ff)
         ST_LOAD: if (accept && req.last_vector) begin
            state_in = ST_RUN; step_in = '0; sep_in = 1'b0;
         end
         ST_RUN: begin
            if (edge_hit || face_hit) sep_in = 1'b1;
            if (step_ff == 5'(obb_pkg::NumSteps - 1)) begin
               state_in = ST_WAIT; drain_in = 2'd2;
            end else step_in = step_ff + 5'd1;
         end
         ST_WAIT: begin
            if (face_hit) sep_in = 1'b1;
            if (drain_ff == 2'd0) state_in = ST_SEND;
            else drain_in = drain_ff - 2'd1;
         end
         ST_SEND: if (rsp.ready) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; step_ff <= '0; drain_ff <= '0; sep_ff <= 1'b0;
         c1_ff <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; drain_ff <= drain_in;
         sep_ff <= sep_in;
         c1_ff <= (state_ff == ST_RUN) ? cur : '0;
      end
      tgt_ff <= tgt;
      if (state_ff == ST_WAIT && drain_ff == 2'd0) res_ff <= !sep_in;
      // merge writes
      case (c1_ff.op)
         obb_pkg::OP_ROT: begin
            rm_ff[tgt_ff[3:0]] <= s;
            ar_ff[tgt_ff[3:0]] <= obb_pkg::sat32(36'(obb_pkg::abs33(s)) + 36'(bias_ff));
         end
         obb_pkg::OP_OFS: t_ff[tgt_ff[1:0]] <= s;
         obb_pkg::OP_RAD: if (tgt_ff >= 5'd3) rad_ff[2'(tgt_ff - 5'd3)] <= s;
         default: ;
      endcase
   end

   // checks
   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req.ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.boxes_overlap))
      else $error("result dropped");
   a_run_to_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ff == 5'(obb_pkg::NumSteps - 1)) |=> state_ff == ST_WAIT)
      else $error("sequencer overrun");
endmodule
`default_nettype wire

// ===== tb/obb_overlap_checker.sv =====
module obb_overlap_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   obb_req_if.sink          req_mon,
   obb_rsp_if.sink          rsp_mon,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Frac = 16;

   logic signed [31:0] box_vectors [0:29];
   logic [15:0]        bias_reg;
   bit                 overlap_expected [$];

   // saturate an exact sum to the signed 32-bit range
   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // fixed-point product, rounded toward minus infinity
   function automatic longint fix_mul(input longint a, input longint b);
      return (a * b) >>> Frac;
   endfunction

   function automatic longint mag(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint vec(input int s, input int k);
      return longint'(box_vectors[s*3+k]);
   endfunction

   // separating axis test on the stored boxes
   function automatic bit boxes_touch();
      longint rm [3][3];
      longint ar [3][3];
      longint d [3];
      longint t [3];
      longint ha [3];
      longint hb [3];
      longint ra, rb, p;
      int i1, i2, j1, j2;
      for (int k = 0; k < 3; k++) begin
         d[k]  = clamp32(vec(5, k) - vec(0, k));
         ha[k] = vec(1, k);
         hb[k] = vec(6, k);
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            rm[i][j] = clamp32(fix_mul(vec(2+i, 0), vec(7+j, 0)) +
                               fix_mul(vec(2+i, 1), vec(7+j, 1)) +
                               fix_mul(vec(2+i, 2), vec(7+j, 2)));
            ar[i][j] = clamp32(mag(rm[i][j]) + longint'(bias_reg));
         end
      for (int i = 0; i < 3; i++)
         t[i] = clamp32(fix_mul(d[0], vec(2+i, 0)) + fix_mul(d[1], vec(2+i, 1)) +
                        fix_mul(d[2], vec(2+i, 2)));
      // face axes of a
      for (int i = 0; i < 3; i++) begin
         rb = clamp32(fix_mul(hb[0], ar[i][0]) + fix_mul(hb[1], ar[i][1]) +
                      fix_mul(hb[2], ar[i][2]));
         if (mag(t[i]) > clamp32(ha[i] + rb)) return 1'b0;
      end
      // face axes of b
      for (int i = 0; i < 3; i++) begin
         ra = clamp32(fix_mul(ha[0], ar[0][i]) + fix_mul(ha[1], ar[1][i]) +
                      fix_mul(ha[2], ar[2][i]));
         p = clamp32(fix_mul(t[0], rm[0][i]) + fix_mul(t[1], rm[1][i]) +
                     fix_mul(t[2], rm[2][i]));
         if (mag(p) > clamp32(ra + hb[i])) return 1'b0;
      end
      // edge cross axes
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            i1 = (i + 1) % 3; i2 = (i + 2) % 3;
            j1 = (j + 1) % 3; j2 = (j + 2) % 3;
            ra = clamp32(fix_mul(ha[i1], ar[i2][j]) + fix_mul(ha[i2], ar[i1][j]));
            rb = clamp32(fix_mul(hb[j1], ar[i][j2]) + fix_mul(hb[j2], ar[i][j1]));
            p = clamp32(fix_mul(t[i2], rm[i1][j]) - fix_mul(t[i1], rm[i2][j]));
            if (mag(p) > clamp32(ra + rb)) return 1'b0;
         end
      return 1'b1;
   endfunction

   assign pending_count = overlap_expected.size();

   // track config, requests and responses
   always @(posedge clock) begin
      if (reset) begin
         bias_reg <= 16'd1;
         fail_count <= 0;
         overlap_expected.delete();
      end else begin
         if (csr_we) bias_reg <= csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.vector_slot < obb_pkg::NumSlots) begin
               box_vectors[req_mon.vector_slot*3+0] = req_mon.comp_x;
               box_vectors[req_mon.vector_slot*3+1] = req_mon.comp_y;
               box_vectors[req_mon.vector_slot*3+2] = req_mon.comp_z;
            end
            if (req_mon.last_vector) overlap_expected.push_back(boxes_touch());
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (overlap_expected.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected response %0b", rsp_mon.boxes_overlap);
            end else if (rsp_mon.boxes_overlap !== overlap_expected[0]) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("overlap mismatch: expected %0b got %0b",
                           overlap_expected[0], rsp_mon.boxes_overlap);
               void'(overlap_expected.pop_front());
            end else begin
               void'(overlap_expected.pop_front());
            end
         end
      end
   end
endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   int          fail_count, pending_count;
   int          cycle_count = 0;

   obb_req_if req_bus ();
   obb_rsp_if rsp_bus ();

   obb_overlap_test_top uut (
      .clock(clock), .reset(reset), .req(req_bus.sink), .rsp(rsp_bus.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata));

   obb_overlap_checker scoreboard (
      .clock(clock), .reset(reset), .req_mon(req_bus.sink), .rsp_mon(rsp_bus.sink),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count));

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.vector_slot = '0;
      req_bus.comp_x = '0;
      req_bus.comp_y = '0;
      req_bus.comp_z = '0;
      req_bus.last_vector = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // random sink stalls, mostly short
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else if ($urandom_range(0, 9) < 6) rsp_bus.ready <= 1'b1;
      else rsp_bus.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
   end

   function automatic logic signed [31:0] rand_word(input int kind);
      case (kind)
         0: return $urandom;
         1: return 32'sh7FFFFFFF;
         2: return 32'sh80000000;
         default: return $signed(32'($urandom_range(0, 32'h00080000))) - 32'sh00040000;
      endcase
   endfunction

   // send one request, waiting for the handshake, with a random gap first
   task automatic send_vector(input logic [3:0] slot, input logic signed [31:0] x,
                              input logic signed [31:0] y, input logic signed [31:0] z,
                              input bit last);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.vector_slot <= slot;
      req_bus.comp_x <= x;
      req_bus.comp_y <= y;
      req_bus.comp_z <= z;
      req_bus.last_vector <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic idle_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_bias(input logic [15:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // load a full pair of boxes with random content, then run the test
   task automatic load_boxes(input int style);
      int kind;
      logic signed [31:0] sz;
      for (int s = 0; s < 10; s++) begin
         kind = (style == 0) ? 3 : $urandom_range(0, 5);
         sz = (s == 1 || s == 6) ? $signed(32'($urandom_range(0, 32'h00040000))) : 32'sd0;
         if (style == 0 && (s == 1 || s == 6))
            send_vector(4'(s), sz, $signed(32'($urandom_range(0, 32'h40000))),
                        $signed(32'($urandom_range(0, 32'h40000))), 1'b0);
         else
            send_vector(4'(s), rand_word(kind), rand_word(kind), rand_word(kind), 1'b0);
      end
      // retest after slot change or out-of-range slot
      send_vector(4'($urandom_range(0, 15)), rand_word(3), rand_word(3), rand_word(3), 1'b1);
   endtask

   initial begin
      int n;
      logic [15:0] bias_set [4];
      bias_set[0] = 16'd0;
      bias_set[1] = 16'hFFFF;
      bias_set[2] = 16'd1;
      bias_set[3] = 16'd64;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identical unit boxes, then extremes
      for (int s = 0; s < 10; s++) begin
         case (s)
            2, 7: send_vector(4'(s), 32'sh10000, 0, 0, 1'b0);
            3, 8: send_vector(4'(s), 0, 32'sh10000, 0, 1'b0);
            4, 9: send_vector(4'(s), 0, 0, 32'sh10000, 1'b0);
            1, 6: send_vector(4'(s), 32'sh10000, 32'sh10000, 32'sh10000, 1'b0);
            default: send_vector(4'(s), 0, 0, 0, 1'b0);
         endcase
      end
      send_vector(4'd5, 32'sh30000, 0, 0, 1'b1);
      send_vector(4'd5, 32'sh18000, 0, 0, 1'b1);
      send_vector(4'd15, 0, 0, 0, 1'b1);
      send_vector(4'd1, -32'sh10000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
      send_vector(4'd0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
      send_vector(4'd2, 32'shFFFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1);
      send_vector(4'd10, 0, 0, 0, 1'b0);
      idle_until_drained();

      // random phases across bias settings
      n = 0;
      for (int phase = 0; phase < 8; phase++) begin
         write_bias(phase < 4 ? bias_set[phase] : 16'($urandom));
         while (n < (phase + 1) * 245) begin
            if ($urandom_range(0, 9) < 8) begin
               load_boxes($urandom_range(0, 3) == 0 ? 1 : 0);
               n += 11;
            end else begin
               send_vector(4'($urandom_range(0, 15)), rand_word($urandom_range(0, 3)),
                           rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)));
               n += 1;
            end
         end
         idle_until_drained();
      end

      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
